>>> rtl/core/ssm_pkg.sv
// shared types and constants of the insertion sorter chain
// no dependencies
`default_nettype none

package ssm_pkg;

  localparam int unsigned DataW = 32;

  typedef logic signed [DataW-1:0] data_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_e;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic pop;
  } ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/split_sort_merge_sorter_core.sv
// top level of the sorter: a row of ssm_cell instances kept in ascending order
// depends on ssm_pkg and ssm_cell
//
// channel  direction  beat contents                                       handshake
// in       input      data_value_i, last_in_set_i                         in_valid_i/in_ready_o
// out      output     sorted_value_o, last_out_o, overflow_flag_o         out_valid_o/out_ready_i
//
// loading takes one beat per cycle, inserted in that cycle; beats beyond MAX_ITEMS are dropped
// after the last beat the set leaves one beat per cycle while out_ready_i is high,
// smallest first, from cell 0; input stalls while emitting
// reset empties the chain (valid bits only), clears the count and the overflow flag
`default_nettype none

module split_sort_merge_sorter_core #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ssm_pkg::data_t data_value_i,
  input  logic           last_in_set_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output ssm_pkg::data_t sorted_value_o,
  output logic           last_out_o,
  output logic           overflow_flag_o,
  output logic           out_valid_o,
  input  logic           out_ready_i
);
  import ssm_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);

  state_e           state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             dropped_q, dropped_d;
  ctrl_t            ctrl;
  logic             in_beat, out_beat, has_room;

  data_t            cell_val   [MAX_ITEMS];
  logic             cell_valid [MAX_ITEMS];
  logic             cell_gt    [MAX_ITEMS];

  assign in_ready_o  = (state_q == ST_LOAD);
  assign out_valid_o = (state_q == ST_EMIT);
  assign in_beat     = in_valid_i && in_ready_o;
  assign out_beat    = out_valid_o && out_ready_i;
  assign has_room    = count_q < CntW'(MAX_ITEMS);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    dropped_d = dropped_q;
    ctrl      = '0;
    case (state_q)
      ST_LOAD: begin
        if (in_beat) begin
          if (has_room) begin
            ctrl.insert = 1'b1;
            count_d     = count_q + CntW'(1);
          end else begin
            dropped_d = 1'b1;
          end
          if (last_in_set_i) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_beat) begin
          ctrl.pop = 1'b1;
          count_d  = count_q - CntW'(1);
          if (count_q == CntW'(1)) begin
            state_d   = ST_LOAD;
            dropped_d = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      count_q   <= '0;
      dropped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
    end
  end

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    data_t left_val, right_val;
    logic  left_gt, left_valid, right_valid;

    if (i == 0) begin : g_first
      assign left_gt    = 1'b0;
      assign left_val   = '0;
      assign left_valid = 1'b0;
    end else begin : g_mid
      assign left_gt    = cell_gt[i-1];
      assign left_val   = cell_val[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_end
      assign right_val   = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_val   = cell_val[i+1];
      assign right_valid = cell_valid[i+1];
    end

    ssm_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_val_i    (data_value_i),
      .left_gt_i    (left_gt),
      .left_val_i   (left_val),
      .left_valid_i (left_valid),
      .right_val_i  (right_val),
      .right_valid_i(right_valid),
      .val_o        (cell_val[i]),
      .valid_o      (cell_valid[i]),
      .gt_o         (cell_gt[i])
    );
  end

  assign sorted_value_o  = cell_val[0];
  assign last_out_o      = (count_q == CntW'(1));
  assign overflow_flag_o = dropped_q;

  // checks
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output open together");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_ITEMS))
    else $error("count beyond capacity");

  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cell_valid[0] && count_q != '0))
    else $error("emitting from an empty chain");

  a_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_beat && last_out_o) |=> (!cell_valid[0] && count_q == '0))
    else $error("chain not empty after the last beat");

endmodule

`default_nettype wire

>>> rtl/core/ssm_cell.sv
// one cell of the sorting chain: holds a value and its valid bit
// depends on ssm_pkg
`default_nettype none

module ssm_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ssm_pkg::ctrl_t ctrl_i,
  input  ssm_pkg::data_t new_val_i,
  input  logic           left_gt_i,
  input  ssm_pkg::data_t left_val_i,
  input  logic           left_valid_i,
  input  ssm_pkg::data_t right_val_i,
  input  logic           right_valid_i,
  output ssm_pkg::data_t val_o,
  output logic           valid_o,
  output logic           gt_o
);
  import ssm_pkg::*;

  data_t val_q, val_d;
  logic  valid_q, valid_d;

  // empty cells act as plus infinity
  assign gt_o    = !valid_q || (val_q > new_val_i);
  assign val_o   = val_q;
  assign valid_o = valid_q;

  always_comb begin
    val_d   = val_q;
    valid_d = valid_q;
    if (ctrl_i.pop) begin
      val_d   = right_val_i;
      valid_d = right_valid_i;
    end else if (ctrl_i.insert && gt_o) begin
      if (left_gt_i) begin
        val_d   = left_val_i;
        valid_d = left_valid_i;
      end else begin
        val_d   = new_val_i;
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

`default_nettype wire
